>>> rtl/ctcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctcg_pkg
// Shared types and constants for the greedy CTC label to UTF-8 decoder.
// ----------------------------------------------------------------------------
package ctcg_pkg;

  localparam int TABLE_DEPTH = 8192;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);

  localparam int LABEL_W = 14;
  localparam int TIDX_W  = 13;
  localparam int CP_W    = 21;
  localparam int BYTE_W  = 8;
  localparam int MAXB    = 4;
  localparam int CNT_W   = 3;

  localparam logic [TIDX_W-1:0] ALPHA_LAST_RST = 13'd8191;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [LABEL_W-1:0] label;
    logic               first_of_sequence;
    logic [TIDX_W-1:0]  table_index;
    logic [CP_W-1:0]    code_point;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] utf8_byte;
    logic              last_byte;
    logic              invalid;
  } out_word_t;

endpackage

>>> rtl/ctc_greedy_label_to_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_greedy_label_to_utf8
// Greedy CTC decoder: drops blanks and repeats, looks labels up in a code
// point table and streams the characters out as UTF-8 bytes.
// ----------------------------------------------------------------------------
// One word is accepted per cycle while in_ready is high. A load word writes the
// character table in the cycle it is accepted; a decode word reads the table in
// that cycle (registered read of the single table port) into rd_data_r, is
// encoded into the byte serializer once it is free, and streams out of byte_r.
// The serializer holds a character until all its UTF-8 bytes (1 to 4) are taken;
// one more character can wait in rd_data_r, and while one waits the input
// stalls. Dropped labels and loads are otherwise taken. The table has no
// reset; entries must be loaded before they are referenced.
module ctc_greedy_label_to_utf8
  import ctcg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              cfg_we,
  input  logic [TIDX_W-1:0] cfg_wdata
);

  logic [CP_W-1:0]    mem [TABLE_DEPTH];

  logic [TIDX_W-1:0]  last_idx_r;
  logic [LABEL_W-1:0] prev_label_r;

  logic               rd_vld_r;
  logic [CP_W-1:0]    rd_data_r;

  logic               ser_vld_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [MAXB-1:0][BYTE_W-1:0] byte_r;
  logic               inv_r;

  logic               in_fire;
  logic               out_fire;
  logic               dec_fire;
  logic               keep_c;
  logic [LABEL_W-1:0] prev_c;
  logic [LABEL_W-1:0] idx_c;
  logic [LABEL_W-1:0] idx_clamp_c;
  logic               advance_c;

  logic [MAXB-1:0][BYTE_W-1:0] enc_bytes_c;
  logic [CNT_W-1:0]   enc_cnt_c;
  logic               enc_inv_c;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign advance_c = rd_vld_r && (!ser_vld_r || (out_ready && cnt_r == CNT_W'(1)));
  assign in_ready  = !rd_vld_r || advance_c;
  assign dec_fire  = in_fire && (in_data.op == OP_DECODE);

  // repeat / blank filter and index clamp
  always_comb begin
    prev_c = in_data.first_of_sequence ? '0 : prev_label_r;
    keep_c = (in_data.label != '0) && (in_data.label != prev_c);
    idx_c  = in_data.label - LABEL_W'(1);
    idx_clamp_c = idx_c;
    if (idx_clamp_c > LABEL_W'(last_idx_r)) begin
      idx_clamp_c = LABEL_W'(last_idx_r);
    end
    if (idx_clamp_c > LABEL_W'(TABLE_DEPTH - 1)) begin
      idx_clamp_c = LABEL_W'(TABLE_DEPTH - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.op == OP_LOAD && int'(in_data.table_index) < TABLE_DEPTH) begin
      mem[in_data.table_index[TBL_AW-1:0]] <= in_data.code_point;
    end
    if (dec_fire) begin
      rd_data_r <= mem[idx_clamp_c[TBL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_idx_r   <= ALPHA_LAST_RST;
      prev_label_r <= '0;
      rd_vld_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        last_idx_r <= cfg_wdata;
      end
      if (dec_fire) begin
        prev_label_r <= in_data.label;
      end
      if (dec_fire && keep_c) begin
        rd_vld_r <= 1'b1;
      end else if (advance_c) begin
        rd_vld_r <= 1'b0;
      end
    end
  end

  // UTF-8 encode
  always_comb begin
    enc_bytes_c = '0;
    enc_cnt_c   = CNT_W'(1);
    enc_inv_c   = 1'b0;
    if ((rd_data_r >= 21'h00D800 && rd_data_r <= 21'h00DFFF) || rd_data_r > 21'h10FFFF) begin
      enc_inv_c = 1'b1;
    end else if (rd_data_r < 21'h000080) begin
      enc_bytes_c[0] = {1'b0, rd_data_r[6:0]};
    end else if (rd_data_r < 21'h000800) begin
      enc_cnt_c      = CNT_W'(2);
      enc_bytes_c[0] = {3'b110, rd_data_r[10:6]};
      enc_bytes_c[1] = {2'b10, rd_data_r[5:0]};
    end else if (rd_data_r < 21'h010000) begin
      enc_cnt_c      = CNT_W'(3);
      enc_bytes_c[0] = {4'b1110, rd_data_r[15:12]};
      enc_bytes_c[1] = {2'b10, rd_data_r[11:6]};
      enc_bytes_c[2] = {2'b10, rd_data_r[5:0]};
    end else begin
      enc_cnt_c      = CNT_W'(4);
      enc_bytes_c[0] = {5'b11110, rd_data_r[20:18]};
      enc_bytes_c[1] = {2'b10, rd_data_r[17:12]};
      enc_bytes_c[2] = {2'b10, rd_data_r[11:6]};
      enc_bytes_c[3] = {2'b10, rd_data_r[5:0]};
    end
  end

  // byte serializer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (advance_c) begin
        ser_vld_r <= 1'b1;
        cnt_r     <= enc_cnt_c;
      end else if (out_fire) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          ser_vld_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance_c) begin
      byte_r <= enc_bytes_c;
      inv_r  <= enc_inv_c;
    end else if (out_fire) begin
      byte_r <= {{BYTE_W{1'b0}}, byte_r[MAXB-1:1]};
    end
  end

  assign out_valid          = ser_vld_r;
  assign out_data.utf8_byte = byte_r[0];
  assign out_data.last_byte = (cnt_r == CNT_W'(1));
  assign out_data.invalid   = inv_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ser_vld_r |-> (cnt_r != '0 && cnt_r <= CNT_W'(MAXB)))
    else $error("serializer count out of range");

  a_inv_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.invalid) |-> (out_data.last_byte && out_data.utf8_byte == '0))
    else $error("invalid word not a single zero byte");

  a_four_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (ser_vld_r && cnt_r == CNT_W'(MAXB)) |-> (byte_r[0][7:3] == 5'b11110))
    else $error("four-byte sequence without four-byte lead");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (rd_vld_r && ser_vld_r))
    else $error("input stalled without pending work");

  a_drop_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (dec_fire && in_data.label == '0) |=> !rd_vld_r)
    else $error("blank label reached the encoder");

endmodule
